// ===== rtl/core/net_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// net_pkg: shared types and constants for the nested escape tokenizer
// Register indexes, word layouts and the stack cell control struct.
// ----------------------------------------------------------------------------
package net_pkg;

    // byte and word widths
    localparam int BYTE_W     = 8;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int PAIRS_MAX  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIRS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_B  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_B = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_C  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_C = 3'd7;

    // reset values
    localparam logic [BYTE_W-1:0] DELIM_RST = 8'd32;

    // output word bit positions
    localparam int OB_TOKEN    = 8;
    localparam int OB_BEGINS   = 9;
    localparam int OB_CLOSED   = 10;
    localparam int OB_OVERFLOW = 11;

    typedef logic [BYTE_W-1:0] t_byte;

    // shift control for the stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

// ===== rtl/core/net_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// net_cell: one entry of the shifting escape stack
// Takes the entry above on a push, the entry below on a pop, else holds.
// ----------------------------------------------------------------------------
module net_cell (
    input  logic              i_clk,
    input  net_pkg::t_cell_ctl i_ctl,
    input  net_pkg::t_byte    i_from_above,  // neighbour nearer the top (or new byte)
    input  net_pkg::t_byte    i_from_below,  // neighbour further down
    output net_pkg::t_byte    o_entry
);

    net_pkg::t_byte r_entry;
    net_pkg::t_byte n_entry;

    // shift selection
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            n_entry = i_from_above;
        end else if (i_ctl.pop) begin
            n_entry = i_from_below;
        end
    end

    // entry is payload only: no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/nested_escape_tokenizer.sv =====
`timescale 1ns / 1ps
// Latency: the result word is registered and appears in the cycle after its input word is taken.
// Throughput: one byte per cycle while the result stream is not stalled; the stack row
// shifts at most once per word, and the pair match and level update are combinational.
// Reset (i_rst_n low, synchronous): nesting level, token state, output valid
// and configuration registers return to their defaults; stack entries do not.
// ----------------------------------------------------------------------------
// nested_escape_tokenizer: delimiter tokenizer with nested escape pairs
// Splits a byte stream into tokens, ignoring the delimiter inside escapes.
// ----------------------------------------------------------------------------
module nested_escape_tokenizer #(
    parameter int NEST_DEPTH = 16,
    parameter int PAIR_COUNT = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [net_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,  // [7:0] char_in
    input  logic                              i_s_axis_tlast,  // end_of_string
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [7:0] char_out, [8] is_token_byte, [9] token_begins, [10] token_closed,
    // [11] nest_overflow, [15:12] zero
    output logic [net_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                              o_m_axis_tlast,  // last_result
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [net_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [net_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LVL_W = $clog2(NEST_DEPTH + 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(NEST_DEPTH);
    localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);
    localparam logic [1:0] PAIR_LIM = 2'(PAIR_COUNT);

    // configuration registers
    net_pkg::t_byte r_delim;
    logic [1:0]     r_pairs;
    net_pkg::t_byte r_open  [net_pkg::PAIRS_MAX];
    net_pkg::t_byte r_close [net_pkg::PAIRS_MAX];

    // control state
    logic [LVL_W-1:0] r_level, n_level;
    logic             r_token_open, n_token_open;

    // output register
    logic                           r_out_valid;
    logic [net_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                           r_out_last;

    logic           accept;
    net_pkg::t_byte c;
    net_pkg::t_byte top;
    logic [1:0]     npairs;
    logic           is_delim, tok, begins, closed, ovf, push, pop, found;
    net_pkg::t_byte push_byte;
    net_pkg::t_cell_ctl cell_ctl;
    net_pkg::t_byte cell_q [NEST_DEPTH];

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign c               = i_s_axis_tdata[net_pkg::BYTE_W-1:0];
    assign top             = cell_q[0];
    assign npairs          = (r_pairs < PAIR_LIM) ? r_pairs : PAIR_LIM;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= net_pkg::DELIM_RST;
            r_pairs <= 2'd0;
            for (int i = 0; i < net_pkg::PAIRS_MAX; i++) begin
                r_open[i]  <= '0;
                r_close[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                net_pkg::REG_DELIM:   r_delim    <= i_cfg_data;
                net_pkg::REG_PAIRS:   r_pairs    <= i_cfg_data[1:0];
                net_pkg::REG_OPEN_A:  r_open[0]  <= i_cfg_data;
                net_pkg::REG_CLOSE_A: r_close[0] <= i_cfg_data;
                net_pkg::REG_OPEN_B:  r_open[1]  <= i_cfg_data;
                net_pkg::REG_CLOSE_B: r_close[1] <= i_cfg_data;
                net_pkg::REG_OPEN_C:  r_open[2]  <= i_cfg_data;
                net_pkg::REG_CLOSE_C: r_close[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify the byte and search the enabled pairs in order
    always_comb begin
        is_delim  = (c == r_delim) && (r_level == '0);
        tok       = !is_delim;
        begins    = tok && !r_token_open;
        found     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        ovf       = 1'b0;
        push_byte = r_open[0];
        for (int i = 0; i < PAIR_COUNT; i++) begin
            if (tok && !found && (2'(i) < npairs)) begin
                if (c == r_open[i]) begin
                    found     = 1'b1;
                    push_byte = r_open[i];
                    if (r_level < LVL_FULL) begin
                        push = 1'b1;
                    end else begin
                        ovf = 1'b1;
                    end
                end else if ((c == r_close[i]) && (r_level != '0) && (top == r_open[i])) begin
                    found = 1'b1;
                    pop   = 1'b1;
                end
            end
        end
        closed = is_delim ? r_token_open : i_s_axis_tlast;
    end

    // next level and token state; end of string clears both
    always_comb begin
        n_level      = r_level;
        n_token_open = r_token_open;
        if (accept) begin
            if (i_s_axis_tlast) begin
                n_level      = '0;
                n_token_open = 1'b0;
            end else begin
                n_token_open = tok;
                if (push) begin
                    n_level = r_level + LVL_ONE;
                end else if (pop) begin
                    n_level = r_level - LVL_ONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= '0;
            r_token_open <= 1'b0;
        end else begin
            r_level      <= n_level;
            r_token_open <= n_token_open;
        end
    end

    // stack row: cell 0 is the top
    assign cell_ctl.push = accept && push;
    assign cell_ctl.pop  = accept && pop;

    for (genvar k = 0; k < NEST_DEPTH; k++) begin : g_cell
        net_pkg::t_byte above, below;
        if (k == 0) begin : g_head
            assign above = push_byte;
        end else begin : g_mid
            assign above = cell_q[k-1];
        end
        if (k == NEST_DEPTH - 1) begin : g_tail
            assign below = cell_q[k];
        end else begin : g_body
            assign below = cell_q[k+1];
        end
        net_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_from_above (above),
            .i_from_below (below),
            .o_entry      (cell_q[k])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= i_s_axis_tvalid;
        end
    end

    // result word: flags above the byte, padding zero
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {{(net_pkg::OUT_DATA_W-net_pkg::OB_OVERFLOW-1){1'b0}},
                           ovf, closed, begins, tok, c};
            r_out_last <= i_s_axis_tlast;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/core/net_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// net_checker: port-level checks for the nested escape tokenizer
// Watches handshakes and result flags; bound to the top level below.
// ----------------------------------------------------------------------------
module net_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           o_s_axis_tready,
    input  logic [net_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [net_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                           o_m_axis_tlast,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [net_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [net_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result word changed while stalled");

    // every accepted byte yields a result word in the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=>
            o_m_axis_tvalid
            && (o_m_axis_tdata[net_pkg::BYTE_W-1:0] == $past(i_s_axis_tdata[net_pkg::BYTE_W-1:0]))
            && (o_m_axis_tlast == $past(i_s_axis_tlast)))
        else $error("result word missing or byte not passed through");

    // a token start or a dropped push only happens on a token byte
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid
            && (o_m_axis_tdata[net_pkg::OB_BEGINS] || o_m_axis_tdata[net_pkg::OB_OVERFLOW])
            |-> o_m_axis_tdata[net_pkg::OB_TOKEN])
        else $error("token flags on a delimiter byte");

    // padding stays zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[net_pkg::OUT_DATA_W-1:net_pkg::OB_OVERFLOW+1] == '0))
        else $error("nonzero padding in result word");

    // register writes are always taken and carry a known index and value
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready && !$isunknown({i_cfg_index, i_cfg_data}))
        else $error("register write refused or unknown");

endmodule

bind nested_escape_tokenizer net_checker u_net_checker (.*);
